### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/sbvm_pkg.sv
// Shared types, codes and sizes of the sparse bound violation merge block.
package sbvm_pkg;

  // Flag store size and derived address width
  localparam int MAX_CONSTRAINTS = 1024;
  localparam int FLAG_AW = $clog2(MAX_CONSTRAINTS);

  // Fixed field widths
  localparam int IDX_W = 10;
  localparam int DATA_W = 32;
  localparam int VALUE_W = 33;
  localparam int INF_W = 32;
  localparam int SUM_W = 48;

  // Stream word widths
  localparam int S_TDATA_W = 136;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 128;
  localparam int M_TUSER_W = 1;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_WS = 2'd1;

  // Output mode codes
  localparam logic [1:0] MODE_SIGN = 2'd0;
  localparam logic [1:0] MODE_RESID = 2'd1;
  localparam logic [1:0] MODE_MAG = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // One in Q16.16
  localparam logic signed [VALUE_W-1:0] ONE_Q16 = 33'sd65536;

  typedef enum logic [1:0] {
    CMD_MERGE = 2'd0,
    CMD_FLAG  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] output_mode;
    logic       use_ws;
  } cfg_t;

  // Classified step handed from front to back
  typedef struct packed {
    logic                      viol;
    logic                      clear;
    logic                      emit;
    logic [IDX_W-1:0]          idx;
    logic signed [VALUE_W-1:0] value;
    logic                      pop_val;
    logic                      pop_lower;
    logic                      pop_upper;
    logic [INF_W-1:0]          mag;
  } work_t;

endpackage

### hw/rtl/sparse_bound_violation_merge.sv
// Top level of the sparse bound violation merge block.
//
//  channel  direction  handshake                word
//  s_       in         s_tvalid / s_tready      merge heads or command
//  m_       out        m_tvalid / m_tready      merge result and norms
//  cfg_     in         cfg_valid / cfg_ready    register index and data
//
// One word per cycle sustained while the queue has room; a result passes the front
// stage, the queue and the output register after its word is taken.
// After reset the flag store is cleared, one entry a cycle over all MAX_CONSTRAINTS (1024)
// entries, with s_tready low; configuration writes are taken.
// The queue lets the front keep accepting while the output word waits.
module sparse_bound_violation_merge (
  input  logic                              clk,
  input  logic                              rst,
  // val_valid, val_index, val_data, lower_valid, lower_index, lower_data,
  // upper_valid, upper_index, upper_data, active_bit, zero pad
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sbvm_pkg::S_TDATA_W-1:0]    s_tdata,
  // command
  input  logic [sbvm_pkg::S_TUSER_W-1:0]    s_tuser,
  // out_index, out_value, pop_val, pop_lower, pop_upper, inf_norm,
  // sum_violation, sum_saturated, zero pad
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sbvm_pkg::M_TDATA_W-1:0]    m_tdata,
  // emit
  output logic [sbvm_pkg::M_TUSER_W-1:0]    m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbvm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbvm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sbvm_pkg::*;

`include "assert_macros.svh"

  cfg_t  cfg;
  logic  fq_valid, fq_ready, qb_valid, qb_ready;
  work_t fq_data, qb_data;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_mode <= MODE_RESID;
      cfg.use_ws      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OUTPUT_MODE: cfg.output_mode <= cfg_data[1:0];
        CFG_USE_WS:      cfg.use_ws <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sbvm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  sbvm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  sbvm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_data   (qb_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // An emitted result carries a nonzero value, any other result a zero value
  `ASSERT_IMPLY(a_emit_value, clk, rst, m_tvalid, m_tuser[0] == |m_tdata[42:10], "emit/value")
  // The saturated flag comes only with a full one norm
  `ASSERT_IMPLY(a_sat_full, clk, rst, m_tdata[126], &m_tdata[125:78], "sat below limit")
  // The infinity norm never exceeds the one norm
  `ASSERT_ALWAYS(a_inf_le_one, clk, rst, SUM_W'(m_tdata[77:46]) <= m_tdata[125:78], "inf > sum")

endmodule

### hw/rtl/sbvm_front.sv
// Front end: accepts words, merges the heads, reads the flag store, classifies.
module sbvm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  sbvm_pkg::cfg_t                  cfg,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sbvm_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [sbvm_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                            q_valid,
  input  logic                            q_ready,
  output sbvm_pkg::work_t                 q_data
);
  import sbvm_pkg::*;

  // Unpacked input fields
  cmd_t                     in_cmd;
  logic                     vv, lv, uv, in_active;
  logic [IDX_W-1:0]         vi, li, ui;
  logic signed [DATA_W-1:0] vd, ld, ud;

  // Merge selection at accept
  logic             accept, any_head, merge;
  logic [IDX_W-1:0] min_idx, sel_idx;
  logic             pv, pl, pu;
  logic             rd_inrange, wr_inrange;

  // Flag store and clearing pass
  logic               flags [MAX_CONSTRAINTS];
  logic               clearing;
  logic [FLAG_AW-1:0] clr_cnt;

  // Front stage register
  logic                     f_valid, f_merge, f_clear, f_flag, f_inrange;
  logic [IDX_W-1:0]         f_idx;
  logic                     f_pv, f_pl, f_pu;
  logic signed [DATA_W-1:0] f_c, f_lb, f_ub;

  // Classification
  logic signed [DATA_W:0] up, lo;
  logic                   viol_up, viol_lo, suppress;
  logic [INF_W-1:0]       mag;

  function automatic logic [FLAG_AW-1:0] flag_addr(input logic [IDX_W-1:0] idx);
    return FLAG_AW'(idx);
  endfunction

  assign in_cmd    = cmd_t'(s_tuser[1:0]);
  assign vv        = s_tdata[0];
  assign vi        = s_tdata[10:1];
  assign vd        = s_tdata[42:11];
  assign lv        = s_tdata[43];
  assign li        = s_tdata[53:44];
  assign ld        = s_tdata[85:54];
  assign uv        = s_tdata[86];
  assign ui        = s_tdata[96:87];
  assign ud        = s_tdata[128:97];
  assign in_active = s_tdata[129];

  assign s_tready = !clearing && (!f_valid || q_ready);
  assign accept   = s_tvalid && s_tready;

  // Pick the smallest index among the valid heads
  always_comb begin
    min_idx = '1;
    if (vv && vi < min_idx) min_idx = vi;
    if (lv && li < min_idx) min_idx = li;
    if (uv && ui < min_idx) min_idx = ui;
  end

  assign any_head   = vv || lv || uv;
  assign merge      = (in_cmd == CMD_MERGE) && any_head;
  assign sel_idx    = merge ? min_idx : '0;
  assign pv         = merge && vv && (vi == min_idx);
  assign pl         = merge && lv && (li == min_idx);
  assign pu         = merge && uv && (ui == min_idx);
  assign rd_inrange = 32'(sel_idx) < MAX_CONSTRAINTS;
  assign wr_inrange = 32'(vi) < MAX_CONSTRAINTS;

  // Clear the flag store after reset, then take flag writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == FLAG_AW'(MAX_CONSTRAINTS - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      flags[clr_cnt] <= 1'b0;
    end else if (accept && in_cmd == CMD_FLAG && wr_inrange) begin
      flags[flag_addr(vi)] <= in_active;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) f_flag <= flags[flag_addr(sel_idx)];
  end

  // Load the front stage on accept, drop it once the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_merge   <= merge;
      f_clear   <= (in_cmd == CMD_CLEAR);
      f_idx     <= sel_idx;
      f_inrange <= rd_inrange;
      f_pv      <= pv;
      f_pl      <= pl;
      f_pu      <= pu;
      f_c       <= pv ? vd : '0;
      f_lb      <= pl ? ld : '0;
      f_ub      <= pu ? ud : '0;
    end
  end

  // Check the bounds; the upper violation wins when both hold
  assign up      = $signed({f_c[DATA_W-1], f_c}) - $signed({f_ub[DATA_W-1], f_ub});
  assign lo      = $signed({f_lb[DATA_W-1], f_lb}) - $signed({f_c[DATA_W-1], f_c});
  assign viol_up = f_merge && !up[DATA_W] && (up != '0);
  assign viol_lo = f_merge && !lo[DATA_W] && (lo != '0);
  assign mag     = viol_up ? up[INF_W-1:0] : (viol_lo ? lo[INF_W-1:0] : '0);
  assign suppress = cfg.use_ws && f_flag && f_inrange;

  always_comb begin
    q_data           = '0;
    q_data.viol      = viol_up || viol_lo;
    q_data.clear     = f_clear;
    q_data.emit      = (viol_up || viol_lo) && !suppress;
    q_data.idx       = f_idx;
    q_data.pop_val   = f_pv;
    q_data.pop_lower = f_pl;
    q_data.pop_upper = f_pu;
    q_data.mag       = mag;
    if (q_data.emit) begin
      unique case (cfg.output_mode)
        MODE_SIGN:  q_data.value = viol_up ? ONE_Q16 : -ONE_Q16;
        MODE_RESID: q_data.value = viol_up ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
        default:    q_data.value = $signed({1'b0, mag});
      endcase
    end
  end

  assign q_valid = f_valid;

endmodule

### hw/rtl/sbvm_queue.sv
// Short queue of classified steps between front and back.
module sbvm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sbvm_pkg::work_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sbvm_pkg::work_t out_data
);
  import sbvm_pkg::*;

  work_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push, pop;

  assign in_ready  = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_data;
  end

endmodule

### hw/rtl/sbvm_back.sv
// Back end: updates the norm accumulators and holds the output word.
module sbvm_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  sbvm_pkg::work_t                q_data,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sbvm_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [sbvm_pkg::M_TUSER_W-1:0] m_tuser
);
  import sbvm_pkg::*;

  logic                      take;
  logic [INF_W-1:0]          inf_acc, inf_next;
  logic [SUM_W-1:0]          one_acc, one_next;
  logic                      sat, sat_next;
  logic [SUM_W:0]            sum_wide;
  logic                      o_emit, o_pv, o_pl, o_pu;
  logic [IDX_W-1:0]          o_idx;
  logic signed [VALUE_W-1:0] o_value;

  assign q_ready = !m_tvalid || m_tready;
  assign take    = q_valid && q_ready;

  // Next norms: clear, or fold in one violation with saturation
  always_comb begin
    inf_next = inf_acc;
    one_next = one_acc;
    sat_next = sat;
    sum_wide = {1'b0, one_acc} + (SUM_W+1)'(q_data.mag);
    if (q_data.clear) begin
      inf_next = '0;
      one_next = '0;
      sat_next = 1'b0;
    end else if (q_data.viol) begin
      if (q_data.mag > inf_acc) inf_next = q_data.mag;
      if (sum_wide[SUM_W]) begin
        one_next = '1;
        sat_next = 1'b1;
      end else begin
        one_next = sum_wide[SUM_W-1:0];
      end
    end
  end

  // Hold the output word until taken; the accumulators are its norm fields
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      inf_acc  <= '0;
      one_acc  <= '0;
      sat      <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
      inf_acc  <= inf_next;
      one_acc  <= one_next;
      sat      <= sat_next;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_emit  <= q_data.emit;
      o_idx   <= q_data.idx;
      o_value <= q_data.value;
      o_pv    <= q_data.pop_val;
      o_pl    <= q_data.pop_lower;
      o_pu    <= q_data.pop_upper;
    end
  end

  assign m_tuser = o_emit;
  assign m_tdata = {1'b0, sat, one_acc, inf_acc, o_pu, o_pl, o_pv, o_value, o_idx};

endmodule

### tb/sv/sparse_bound_violation_merge_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the sparse bound violation merge block.
module sparse_bound_violation_merge_tb;
  import sbvm_pkg::*;

  // Run shape
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 6;
  localparam int TAIL_CYCLES = 10;
  localparam int RAND_PHASES = 10;
  localparam int RAND_PER_PHASE = 85;
  localparam int STEADY_BURST = 50;
  localparam int HOT_SPAN = 24;
  localparam int DIR_ROWS = 24;

  // Codes the package leaves unnamed
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  // Q16.16 constants
  localparam logic [31:0] Q_ZERO = 32'h0000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_TWO = 32'h0002_0000;
  localparam logic [31:0] Q_FOUR = 32'h0004_0000;
  localparam logic [31:0] Q_NEG_TWO = 32'hFFFE_0000;
  localparam logic [31:0] Q_NEG_LSB = 32'hFFFF_FFFF;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam longint SUM_LIMIT = 64'h0000_FFFF_FFFF_FFFF;

  localparam logic N = 1'b0;
  localparam logic Y = 1'b1;

  // Input word, last member in the lowest bits
  typedef struct packed {
    logic [5:0]  pad;
    logic        active;
    logic [31:0] upper_data;
    logic [9:0]  upper_index;
    logic        upper_valid;
    logic [31:0] lower_data;
    logic [9:0]  lower_index;
    logic        lower_valid;
    logic [31:0] val_data;
    logic [9:0]  val_index;
    logic        val_valid;
  } heads_t;

  // Result word, last member in the lowest bits
  typedef struct packed {
    logic        pad;
    logic        sat;
    logic [47:0] sum;
    logic [31:0] inf;
    logic        pop_upper;
    logic        pop_lower;
    logic        pop_val;
    logic [32:0] value;
    logic [9:0]  idx;
  } result_word_t;

  typedef struct packed {
    logic         emit;
    result_word_t w;
  } merge_result_t;

  // One directed row: settings, command, heads, and an optional typed result
  typedef struct packed {
    logic [1:0]  mode;
    logic        ws;
    cmd_t        cmd;
    logic        vv;
    logic [9:0]  vi;
    logic [31:0] vd;
    logic        lv;
    logic [9:0]  li;
    logic [31:0] ld;
    logic        uv;
    logic [9:0]  ui;
    logic [31:0] ud;
    logic        act;
    logic        typed;
    logic        emit;
    logic [9:0]  idx;
    logic [32:0] value;
    logic [2:0]  pops;
  } row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state
  logic [MAX_CONSTRAINTS-1:0] flag_store;
  logic [31:0] inf_acc;
  logic [47:0] sum_acc;
  logic sum_sat;
  logic [1:0] cur_mode;
  logic cur_ws;

  merge_result_t pending_results[$];

  int cycles = 0;
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int emits_seen = 0;
  int reg_writes = 0;
  logic sat_seen = 1'b0;
  logic calm = 1'b0;
  logic steady = 1'b0;

  // Directed rows: mode, ws, cmd, heads, active bit, then typed result if any
  row_t dir_rows [0:DIR_ROWS-1] = '{
    // no valid head
    '{MODE_RESID, N, CMD_MERGE, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, N,
      Y, N, 10'd0, 33'sd0, 3'b000},
    // value only, absent bounds read as zero
    '{MODE_RESID, N, CMD_MERGE, Y, 10'd5, Q_ONE, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, N,
      Y, Y, 10'd5, 33'sd65536, 3'b100},
    // all heads at zero, inside bounds
    '{MODE_RESID, N, CMD_MERGE, Y, 10'd0, Q_ZERO, Y, 10'd0, Q_ZERO, Y, 10'd0, Q_ZERO, Y,
      Y, N, 10'd0, 33'sd0, 3'b111},
    // largest upper residual
    '{MODE_RESID, N, CMD_MERGE, Y, 10'd1023, Q_MAX, Y, 10'd1023, Q_MIN, Y, 10'd1023, Q_MIN, N,
      Y, Y, 10'd1023, 33'sd4294967295, 3'b111},
    // largest lower residual
    '{MODE_RESID, N, CMD_MERGE, Y, 10'd1023, Q_MIN, Y, 10'd1023, Q_MAX, Y, 10'd1023, Q_MAX, N,
      Y, Y, 10'd1023, -33'sd4294967295, 3'b111},
    // crossed bounds, upper side wins
    '{MODE_RESID, N, CMD_MERGE, Y, 10'd7, Q_ZERO, Y, 10'd7, Q_TWO, Y, 10'd7, Q_NEG_TWO, N,
      Y, Y, 10'd7, 33'sd131072, 3'b111},
    // lower head has the smallest index
    '{MODE_RESID, N, CMD_MERGE, Y, 10'd10, Q_ZERO, Y, 10'd3, Q_ONE, Y, 10'd8, Q_ZERO, N,
      Y, Y, 10'd3, -33'sd65536, 3'b010},
    // mark entries 7 and 1023 active
    '{MODE_RESID, N, CMD_FLAG, Y, 10'd7, Q_ONE, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, Y,
      Y, N, 10'd0, 33'sd0, 3'b000},
    '{MODE_RESID, N, CMD_FLAG, N, 10'd1023, Q_ZERO, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, Y,
      Y, N, 10'd0, 33'sd0, 3'b000},
    // idle and clear commands with violating heads
    '{MODE_RESID, N, CMD_NOP, Y, 10'd2, Q_MAX, Y, 10'd2, Q_ZERO, Y, 10'd2, Q_ZERO, Y,
      Y, N, 10'd0, 33'sd0, 3'b000},
    '{MODE_RESID, N, CMD_CLEAR, Y, 10'd2, Q_MAX, Y, 10'd2, Q_ZERO, Y, 10'd2, Q_ZERO, N,
      Y, N, 10'd0, 33'sd0, 3'b000},
    // smallest upper residual
    '{MODE_RESID, N, CMD_MERGE, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, Y, 10'd0, Q_NEG_LSB, N,
      Y, Y, 10'd0, 33'sd1, 3'b001},
    // sign mode with working set: active entries stay quiet
    '{MODE_SIGN, Y, CMD_MERGE, Y, 10'd7, Q_ONE, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, N,
      Y, N, 10'd7, 33'sd0, 3'b100},
    '{MODE_SIGN, Y, CMD_MERGE, Y, 10'd8, Q_ONE, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, N,
      Y, Y, 10'd8, 33'sd65536, 3'b100},
    '{MODE_SIGN, Y, CMD_MERGE, N, 10'd0, Q_ZERO, Y, 10'd9, Q_ONE, N, 10'd0, Q_ZERO, N,
      Y, Y, 10'd9, -33'sd65536, 3'b010},
    '{MODE_SIGN, Y, CMD_MERGE, N, 10'd0, Q_ZERO, Y, 10'd1023, Q_MAX, N, 10'd0, Q_ZERO, N,
      Y, N, 10'd1023, 33'sd0, 3'b010},
    '{MODE_SIGN, Y, CMD_MERGE, Y, 10'd1023, Q_ONE, Y, 10'd1023, Q_ZERO, Y, 10'd1023, Q_TWO, N,
      Y, N, 10'd1023, 33'sd0, 3'b111},
    // magnitude mode ignores flags when the working set is off
    '{MODE_MAG, N, CMD_MERGE, Y, 10'd7, Q_ONE, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, N,
      Y, Y, 10'd7, 33'sd65536, 3'b100},
    '{MODE_MAG, N, CMD_MERGE, N, 10'd0, Q_ZERO, Y, 10'd4, Q_ONE, N, 10'd0, Q_ZERO, N,
      Y, Y, 10'd4, 33'sd65536, 3'b010},
    '{MODE_MAG, N, CMD_FLAG, N, 10'd7, Q_ZERO, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, N,
      Y, N, 10'd0, 33'sd0, 3'b000},
    // spare mode code behaves as magnitude
    '{MODE_SPARE, Y, CMD_MERGE, N, 10'd0, Q_ZERO, Y, 10'd7, Q_TWO, N, 10'd0, Q_ZERO, N,
      Y, Y, 10'd7, 33'sd131072, 3'b010},
    '{MODE_SPARE, Y, CMD_MERGE, Y, 10'd12, 32'h1234_5678, Y, 10'd12, 32'h2000_0000,
      Y, 10'd13, 32'h0000_0042, N, N, N, 10'd0, 33'sd0, 3'b000},
    '{MODE_SPARE, Y, CMD_MERGE, Y, 10'd40, 32'hC000_0001, N, 10'd0, Q_ZERO,
      Y, 10'd40, 32'hBFFF_0000, Y, N, N, 10'd0, 33'sd0, 3'b000},
    '{MODE_SPARE, Y, CMD_CLEAR, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, N, 10'd0, Q_ZERO, N,
      Y, N, 10'd0, 33'sd0, 3'b000}
  };

  sparse_bound_violation_merge i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Count cycles, toggle calm stretches, stop on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 250 == 249) begin
      calm <= ($urandom_range(0, 3) == 0);
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("sparse_bound_violation_merge_tb: FAIL");
      $finish;
    end
  end

  // Work out the result word of one accepted input word and advance the state
  function automatic merge_result_t predict_step(input cmd_t cmd, input heads_t h);
    merge_result_t r;
    logic [9:0] pick;
    longint c, lb, ub, up, lo, mag, total;
    logic viol, above;
    r = '0;
    c = 0;
    lb = 0;
    ub = 0;
    mag = 0;
    viol = 1'b0;
    above = 1'b0;
    pick = '1;
    if (cmd == CMD_MERGE && (h.val_valid || h.lower_valid || h.upper_valid)) begin
      if (h.val_valid && h.val_index < pick) pick = h.val_index;
      if (h.lower_valid && h.lower_index < pick) pick = h.lower_index;
      if (h.upper_valid && h.upper_index < pick) pick = h.upper_index;
      if (h.val_valid && h.val_index == pick) begin
        r.w.pop_val = 1'b1;
        c = longint'($signed(h.val_data));
      end
      if (h.lower_valid && h.lower_index == pick) begin
        r.w.pop_lower = 1'b1;
        lb = longint'($signed(h.lower_data));
      end
      if (h.upper_valid && h.upper_index == pick) begin
        r.w.pop_upper = 1'b1;
        ub = longint'($signed(h.upper_data));
      end
      r.w.idx = pick;
      up = c - ub;
      lo = lb - c;
      // upper violation takes priority over lower
      if (up > 0) begin
        viol = 1'b1;
        above = 1'b1;
        mag = up;
      end else if (lo > 0) begin
        viol = 1'b1;
        mag = lo;
      end
      if (viol) begin
        if (mag > longint'(inf_acc)) inf_acc = mag[31:0];
        total = longint'(sum_acc) + mag;
        if (total > SUM_LIMIT) begin
          total = SUM_LIMIT;
          sum_sat = 1'b1;
        end
        sum_acc = total[47:0];
        if (!(cur_ws && flag_store[pick])) begin
          r.emit = 1'b1;
          case (cur_mode)
            MODE_SIGN: r.w.value = above ? ONE_Q16 : -ONE_Q16;
            MODE_RESID: r.w.value = above ? mag[32:0] : 33'(-mag);
            default: r.w.value = mag[32:0];
          endcase
        end
      end
    end else if (cmd == CMD_FLAG) begin
      flag_store[h.val_index] = h.active;
    end else if (cmd == CMD_CLEAR) begin
      inf_acc = '0;
      sum_acc = '0;
      sum_sat = 1'b0;
    end
    r.w.inf = inf_acc;
    r.w.sum = sum_acc;
    r.w.sat = sum_sat;
    return r;
  endfunction

  // Idle length for either side: mostly none or short, a few long
  function automatic int gap_length();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2, 3: return $urandom;
      default: return $urandom_range(0, 2 * Q_FOUR) - Q_FOUR;
    endcase
  endfunction

  // Keep head indices close so that ties and pops of several heads are common
  function automatic logic [9:0] near_index(input logic [9:0] base);
    logic [9:0] step;
    step = 10'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0 || base > 10'd1019) return base;
    return base + step;
  endfunction

  function automatic heads_t rand_heads();
    heads_t h;
    logic [9:0] base;
    h = '0;
    base = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, HOT_SPAN - 1));
    h.val_valid = ($urandom_range(0, 7) != 0);
    h.val_index = near_index(base);
    h.val_data = rand_value();
    h.lower_valid = ($urandom_range(0, 7) != 0);
    h.lower_index = near_index(base);
    h.lower_data = rand_value();
    h.upper_valid = ($urandom_range(0, 7) != 0);
    h.upper_index = near_index(base);
    h.upper_data = rand_value();
    h.active = 1'($urandom);
    return h;
  endfunction

  function automatic cmd_t pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return CMD_MERGE;
    if (roll < 92) return CMD_FLAG;
    if (roll < 96) return CMD_CLEAR;
    return CMD_NOP;
  endfunction

  task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
    $display("cycle %0d: %s mismatch, got %0d, expected %0d", cycles, what, got_v, want_v);
    mismatches++;
  endtask

  // Present one input word and hold it until taken
  task automatic issue(input cmd_t cmd, input heads_t h, output merge_result_t r);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= h;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_step(cmd, h);
    words_sent++;
  endtask

  task automatic pause_sender();
    int n;
    n = steady ? 0 : gap_length();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_word(input cmd_t cmd, input heads_t h);
    merge_result_t r;
    issue(cmd, h, r);
    pending_results.push_back(r);
    pause_sender();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_OUTPUT_MODE: cur_mode = data;
      CFG_USE_WS: cur_ws = data[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Drain the block, then write both registers (and now and then an unused index)
  task automatic apply_settings(input logic [1:0] mode, input logic ws);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_OUTPUT_MODE, mode);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(($urandom_range(0, 1) == 0) ? CFG_UNUSED_A : CFG_UNUSED_B, 2'($urandom));
    end
    write_reg(CFG_USE_WS, {1'($urandom), ws});
    cfg_valid <= 1'b0;
  endtask

  // Take result words and compare them with the oldest expectation
  initial begin : result_sink
    merge_result_t got, want;
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.emit = m_tuser[0];
        got.w = m_tdata;
        results_seen++;
        if (got.emit) emits_seen++;
        if (got.w.sat) sat_seen = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.emit !== want.emit) report_mismatch("emit", got.emit, want.emit);
          if (got.w.idx !== want.w.idx) report_mismatch("out_index", got.w.idx, want.w.idx);
          if (got.w.value !== want.w.value) begin
            report_mismatch("out_value", longint'($signed(got.w.value)),
                            longint'($signed(want.w.value)));
          end
          if (got.w.pop_val !== want.w.pop_val)
            report_mismatch("pop_val", got.w.pop_val, want.w.pop_val);
          if (got.w.pop_lower !== want.w.pop_lower)
            report_mismatch("pop_lower", got.w.pop_lower, want.w.pop_lower);
          if (got.w.pop_upper !== want.w.pop_upper)
            report_mismatch("pop_upper", got.w.pop_upper, want.w.pop_upper);
          if (got.w.inf !== want.w.inf) report_mismatch("inf_norm", got.w.inf, want.w.inf);
          if (got.w.sum !== want.w.sum) report_mismatch("sum_violation", got.w.sum, want.w.sum);
          if (got.w.sat !== want.w.sat) report_mismatch("sum_saturated", got.w.sat, want.w.sat);
        end
      end
      // Stall the output at random, never during steady stretches
      if (steady) begin
        stall = 0;
        m_tready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        stall = gap_length();
        m_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin : stimulus
    merge_result_t r;
    heads_t h;
    row_t row;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_MERGE;
    cfg_valid = 1'b0;
    cfg_index = CFG_OUTPUT_MODE;
    cfg_data = '0;
    flag_store = '0;
    inf_acc = '0;
    sum_acc = '0;
    sum_sat = 1'b0;
    cur_mode = MODE_RESID;
    cur_ws = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; typed results replace the predicted index, value and pops
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.mode != cur_mode || row.ws != cur_ws) apply_settings(row.mode, row.ws);
      h = '0;
      h.val_valid = row.vv;
      h.val_index = row.vi;
      h.val_data = row.vd;
      h.lower_valid = row.lv;
      h.lower_index = row.li;
      h.lower_data = row.ld;
      h.upper_valid = row.uv;
      h.upper_index = row.ui;
      h.upper_data = row.ud;
      h.active = row.act;
      issue(row.cmd, h, r);
      if (row.typed) begin
        r.emit = row.emit;
        r.w.idx = row.idx;
        r.w.value = row.value;
        {r.w.pop_val, r.w.pop_lower, r.w.pop_upper} = row.pops;
      end
      pending_results.push_back(r);
      pause_sender();
    end

    // Random words under a series of settings, extremes first
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 4) apply_settings(2'(p), logic'(p % 2 == 0));
      else apply_settings(2'($urandom_range(0, 3)), 1'($urandom));
      repeat (RAND_PER_PHASE) send_word(pick_command(), rand_heads());
    end

    // Run largest residuals back to back with the output always ready
    apply_settings(MODE_RESID, 1'b0);
    steady = 1'b1;
    h = '0;
    h.val_valid = 1'b1;
    h.val_index = '1;
    h.val_data = Q_MAX;
    h.upper_valid = 1'b1;
    h.upper_index = '1;
    h.upper_data = Q_MIN;
    send_word(CMD_CLEAR, h);
    repeat (STEADY_BURST) send_word(CMD_MERGE, h);
    steady = 1'b0;
    repeat (20) send_word(pick_command(), rand_heads());
    send_word(CMD_CLEAR, h);
    send_word(CMD_MERGE, h);

    // Wait out the last results
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d input words, %0d result words (%0d emitted), %0d register writes",
             words_sent, results_seen, emits_seen, reg_writes);
    $display("one norm saturation reached: %0s, mismatches: %0d",
             sat_seen ? "yes" : "no", mismatches);
    if (mismatches == 0) begin
      $display("sparse_bound_violation_merge_tb: PASS");
    end else begin
      $display("sparse_bound_violation_merge_tb: FAIL");
    end
    $finish;
  end

endmodule
